FILE: src/nqpt_pkg.sv
// Shared types, codes and constants of the NVMe queue pair tracker.
package nqpt_pkg;

    // Default number of entries per submission and completion queue
    localparam int QUEUE_DEPTH_DEF = 64;
    // Reset value of the queue depth register
    localparam int CFG_DEPTH_RESET = 64;
    localparam int CFG_W           = 7;

    // Stripe set geometry: two devices, stripes of 4096 / 512 blocks
    localparam int DEVICES       = 2;
    localparam int STRIPE_BLOCKS = 4096 / 512;
    localparam int DEV_W         = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int STRIPE_SHIFT  = $clog2(STRIPE_BLOCKS);

    // Depth of the queue between front and back end
    localparam int Q_DEPTH = 2;

    // Item modes
    localparam logic [1:0] MODE_SUBMIT   = 2'd0;
    localparam logic [1:0] MODE_COMPLETE = 2'd1;
    localparam logic [1:0] MODE_POLL     = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_BUSY  = 2'd1;
    localparam logic [1:0] STAT_STALE = 2'd2;

    // Slot states
    localparam logic [1:0] SLOT_INFLIGHT = 2'd0;
    localparam logic [1:0] SLOT_DONE     = 2'd1;
    localparam logic [1:0] SLOT_UNUSED   = 2'd2;

    // Command opcodes
    localparam logic [7:0] OPC_WRITE = 8'h01;
    localparam logic [7:0] OPC_READ  = 8'h02;

    typedef logic [DEV_W-1:0] t_dev;

    // Classified word passed from the front end to the back end
    typedef struct packed {
        logic [1:0]  mode;
        t_dev        dev;
        logic [5:0]  cid;
        logic        cid_ok;
        logic        phase;
        logic [7:0]  opcode;
        logic [31:0] daddr;
        logic [15:0] bm1;
    } t_q_item;

    // Result word
    typedef struct packed {
        logic [1:0]  status;
        logic        device_out;
        logic [5:0]  slot_id;
        logic [7:0]  opcode;
        logic [31:0] daddr;
        logic [15:0] bm1;
        logic [5:0]  doorbell;
        logic        is_done;
    } t_result;

    // Queue status seen by the front end
    typedef struct packed {
        logic full;
        logic clearing;
    } t_front_ctl;

endpackage

FILE: src/nqpt_front.sv
// Front end: accepts input words, maps stripes and builds the queue word.
module nqpt_front #(
    parameter int QUEUE_DEPTH = nqpt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_mode,
    input  logic [31:0]        i_block_address,
    input  logic [16:0]        i_block_count,
    input  logic               i_is_write,
    input  logic               i_device_index,
    input  logic [5:0]         i_command_id,
    input  logic               i_entry_phase,
    input  nqpt_pkg::t_front_ctl i_ctl,
    output logic               o_push,
    output nqpt_pkg::t_q_item  o_item
);
    import nqpt_pkg::*;

    logic [31:0] stripe;
    logic [31:0] dev_addr;
    t_dev        stripe_dev;

    // Accept while the queue has room and the slot table is not being cleared
    assign o_in_stall = i_ctl.full | i_ctl.clearing;
    assign o_push     = i_in_valid & ~o_in_stall;

    // Stripe mapping: device is the low stripe bits, the rest forms the device address
    assign stripe     = i_block_address >> STRIPE_SHIFT;
    assign stripe_dev = stripe[DEV_W-1:0];
    assign dev_addr   = ((stripe >> DEV_W) << STRIPE_SHIFT)
                      | (i_block_address & 32'(STRIPE_BLOCKS - 1));

    // Classify by mode; opcode, address and count stay zero outside submit
    always_comb begin
        o_item        = '0;
        o_item.mode   = i_mode;
        o_item.cid    = i_command_id;
        o_item.cid_ok = ({26'd0, i_command_id} < 32'(QUEUE_DEPTH));
        o_item.phase  = i_entry_phase;
        unique case (i_mode)
            MODE_SUBMIT: begin
                o_item.dev    = stripe_dev;
                o_item.opcode = i_is_write ? OPC_WRITE : OPC_READ;
                o_item.daddr  = dev_addr;
                o_item.bm1    = 16'(i_block_count - 17'd1);
            end
            MODE_COMPLETE: begin
                o_item.dev = DEV_W'(i_device_index);
            end
            MODE_POLL: begin
                o_item.dev = stripe_dev;
            end
            default: begin
                o_item.dev = '0;
            end
        endcase
    end

endmodule

FILE: src/nqpt_fifo.sv
// Two-word queue between the front end and the back end.
module nqpt_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  nqpt_pkg::t_q_item i_item,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output nqpt_pkg::t_q_item o_item
);
    import nqpt_pkg::*;

    localparam int QP_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W = $clog2(Q_DEPTH + 1);

    t_q_item           r_mem [Q_DEPTH];
    logic [QP_W-1:0]   r_wr;
    logic [QP_W-1:0]   r_rd;
    logic [QC_W-1:0]   r_count;

    assign o_full  = (r_count == QC_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QP_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QP_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not advance on push");
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> r_count == $past(r_count) - 1'b1)
        else $error("queue count did not drop on pop");

endmodule

FILE: src/nqpt_back.sv
// Back end: slot table, queue pointers, phase tracking and result register.
module nqpt_back #(
    parameter int QUEUE_DEPTH = nqpt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [nqpt_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                 i_q_valid,
    input  nqpt_pkg::t_q_item    i_q_item,
    output logic                 o_q_pop,
    output logic                 o_clearing,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output nqpt_pkg::t_result    o_result
);
    import nqpt_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int DU_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = DEV_W + PTR_W;
    localparam int DEPTH_RST = (CFG_DEPTH_RESET > QUEUE_DEPTH) ? QUEUE_DEPTH
                                                               : CFG_DEPTH_RESET;

    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } t_state;

    t_state          r_state;
    logic [ADDR_W-1:0] r_clr;
    logic [DU_W-1:0] r_depth;
    t_ptr            r_tail  [DEVICES];
    t_ptr            r_head  [DEVICES];
    logic            r_phase [DEVICES];
    logic            r_out_valid;
    t_result         r_out;
    t_q_item         r_item;
    t_ptr            r_ptr;
    t_addr           r_addr;

    // Slot state table
    logic [1:0]      r_slots [2**ADDR_W];
    logic [1:0]      r_rd_data;

    logic            out_free;
    logic            commit;
    t_ptr            head_tail;
    t_addr           rd_addr;
    logic            mem_we;
    t_addr           mem_waddr;
    logic [1:0]      mem_wdata;
    logic            upd_we;
    logic [1:0]      upd_data;
    logic            tail_we;
    logic            head_we;
    logic            phase_flip;
    t_ptr            sub_adv;
    t_ptr            head_cur;
    logic [PTR_W:0]  head_inc;
    logic            head_wrap;
    t_ptr            head_nxt;
    t_result         n_out;

    function automatic t_ptr advance(t_ptr p, logic [DU_W-1:0] depth);
        logic [PTR_W:0] n;
        n = {1'b0, p} + 1'b1;
        return (32'(n) >= 32'(depth)) ? '0 : PTR_W'(n);
    endfunction

    function automatic logic [DU_W-1:0] clamp_depth(logic [CFG_W-1:0] v);
        logic [DU_W-1:0] d;
        if (v < CFG_W'(2)) begin
            d = DU_W'(2);
        end else if (32'(v) > 32'(QUEUE_DEPTH)) begin
            d = DU_W'(QUEUE_DEPTH);
        end else begin
            d = DU_W'(v);
        end
        return d;
    endfunction

    assign o_clearing  = (r_state == S_CLEAR);
    assign out_free    = ~r_out_valid | ~i_out_stall;
    assign commit      = (r_state == S_LOOK) && out_free;
    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    // Read address of the word at the queue head
    assign head_tail = r_tail[i_q_item.dev];
    assign rd_addr   = (i_q_item.mode == MODE_SUBMIT) ? {i_q_item.dev, head_tail}
                                                      : {i_q_item.dev, PTR_W'(i_q_item.cid)};

    // Pointer arithmetic for the word under lookup
    assign sub_adv   = advance(r_ptr, r_depth);
    assign head_cur  = r_head[r_item.dev];
    assign head_inc  = {1'b0, head_cur} + 1'b1;
    assign head_wrap = (32'(head_inc) >= 32'(r_depth));
    assign head_nxt  = head_wrap ? '0 : PTR_W'(head_inc);

    // Decide the result and the state updates of the word under lookup
    always_comb begin
        n_out      = '0;
        upd_we     = 1'b0;
        upd_data   = SLOT_INFLIGHT;
        tail_we    = 1'b0;
        head_we    = 1'b0;
        phase_flip = 1'b0;
        unique case (r_item.mode)
            MODE_SUBMIT: begin
                n_out.device_out = 1'(r_item.dev);
                n_out.slot_id    = 6'(r_ptr);
                n_out.opcode     = r_item.opcode;
                n_out.daddr      = r_item.daddr;
                n_out.bm1        = r_item.bm1;
                if (r_rd_data == SLOT_INFLIGHT) begin
                    n_out.status   = STAT_BUSY;
                    n_out.doorbell = 6'(r_ptr);
                end else begin
                    n_out.status   = STAT_OK;
                    n_out.doorbell = 6'(sub_adv);
                    upd_we         = 1'b1;
                    upd_data       = SLOT_INFLIGHT;
                    tail_we        = 1'b1;
                end
            end
            MODE_COMPLETE: begin
                n_out.device_out = 1'(r_item.dev);
                n_out.slot_id    = r_item.cid;
                if (r_item.phase != r_phase[r_item.dev]) begin
                    n_out.status   = STAT_STALE;
                    n_out.doorbell = 6'(head_cur);
                end else begin
                    n_out.status   = STAT_OK;
                    n_out.doorbell = 6'(head_nxt);
                    upd_we         = r_item.cid_ok;
                    upd_data       = SLOT_DONE;
                    head_we        = 1'b1;
                    phase_flip     = head_wrap;
                end
            end
            MODE_POLL: begin
                n_out.device_out = 1'(r_item.dev);
                n_out.slot_id    = r_item.cid;
                n_out.is_done    = r_item.cid_ok && (r_rd_data == SLOT_DONE);
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    // Slot table write port: clearing pass or commit
    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = SLOT_UNUSED;
        end else begin
            mem_we    = commit & upd_we;
            mem_waddr = r_addr;
            mem_wdata = upd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slots[mem_waddr] <= mem_wdata;
        end
        if (o_q_pop) begin
            r_rd_data <= r_slots[rd_addr];
        end
    end

    // Control state, pointers and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_depth     <= DU_W'(DEPTH_RST);
            r_out_valid <= 1'b0;
            for (int d = 0; d < DEVICES; d++) begin
                r_tail[d]  <= '0;
                r_head[d]  <= '0;
                r_phase[d] <= 1'b1;
            end
        end else begin
            if (i_cfg_we) begin
                r_depth <= clamp_depth(i_cfg_data);
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (commit && tail_we) begin
                r_tail[r_item.dev] <= sub_adv;
            end
            if (commit && head_we) begin
                r_head[r_item.dev] <= head_nxt;
            end
            if (commit && phase_flip) begin
                r_phase[r_item.dev] <= ~r_phase[r_item.dev];
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Word under lookup and result payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
            r_ptr  <= head_tail;
            r_addr <= rd_addr;
        end
        if (commit) begin
            r_out <= n_out;
        end
    end

    a_pop_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_state == S_LOOK)
        else $error("popped word not looked up");
    a_wait_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK && !out_free) |=> r_state == S_LOOK && $stable(r_item))
        else $error("word under lookup lost while result blocked");
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid)
        else $error("committed result not presented");
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid && !o_q_pop)
        else $error("activity during slot table clearing");

endmodule

FILE: src/nvme_queue_pair_tracker.sv
// Top level of the NVMe queue pair tracker: front end, queue and back end.
//
// Host-side bookkeeping for NVMe submission/completion queue pairs of a
// two-device stripe set (8-block stripes). The front end takes one input word
// per cycle, unless stalled, into a two-word queue; the back end handles each
// word as a slot-state table read, then update and result, and pops a new
// word only once the last one is committed. A result register decouples the
// output: a new word is taken while a result still waits. After reset the
// slot table, DEVICES * 2**ceil(log2(QUEUE_DEPTH)) entries (128 at the
// defaults), is cleared one entry per cycle; the input stalls during that
// pass, config writes are still taken. The queue_depth register must only
// be written while the block is idle.
module nvme_queue_pair_tracker #(
    parameter int QUEUE_DEPTH = nqpt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_block_address,
    input  logic [16:0] i_block_count,
    input  logic        i_is_write,
    input  logic        i_device_index,
    input  logic [5:0]  i_command_id,
    input  logic        i_entry_phase,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_device_out,
    output logic [5:0]  o_slot_id,
    output logic [7:0]  o_opcode,
    output logic [31:0] o_device_block_address,
    output logic [15:0] o_blocks_minus_one,
    output logic [5:0]  o_doorbell_value,
    output logic        o_is_done
);
    import nqpt_pkg::*;

    t_front_ctl front_ctl;
    logic       push;
    t_q_item    push_item;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    t_q_item    q_item;
    logic       clearing;
    t_result    result;

    assign front_ctl.full     = q_full;
    assign front_ctl.clearing = clearing;

    nqpt_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_block_address (i_block_address),
        .i_block_count   (i_block_count),
        .i_is_write      (i_is_write),
        .i_device_index  (i_device_index),
        .i_command_id    (i_command_id),
        .i_entry_phase   (i_entry_phase),
        .i_ctl           (front_ctl),
        .o_push          (push),
        .o_item          (push_item)
    );

    nqpt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    nqpt_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_status               = result.status;
    assign o_device_out           = result.device_out;
    assign o_slot_id              = result.slot_id;
    assign o_opcode               = result.opcode;
    assign o_device_block_address = result.daddr;
    assign o_blocks_minus_one     = result.bm1;
    assign o_doorbell_value       = result.doorbell;
    assign o_is_done              = result.is_done;

endmodule
